@@ rtl/ctg_pkg.sv @@
// Shared types, constants and helpers for the cubic trajectory generator.
// Used by the top level and by the serial divider; no dependencies.
package ctg_pkg;

  localparam int COEF_W       = 64;
  localparam int DIV_W        = 128;
  localparam int MUL_W        = 32;
  localparam int MIN_DURATION = 66;

  typedef logic [COEF_W-1:0] coef_t;

  // operand A select
  localparam logic [2:0] A_RA  = 3'd0;
  localparam logic [2:0] A_RB  = 3'd1;
  localparam logic [2:0] A_RC  = 3'd2;
  localparam logic [2:0] A_RD  = 3'd3;
  localparam logic [2:0] A_C2  = 3'd4;
  localparam logic [2:0] A_C3  = 3'd5;
  localparam logic [2:0] A_DUR = 3'd6;

  // multiplier operand select
  localparam logic [2:0] M_DUR   = 3'd0;
  localparam logic [2:0] M_T     = 3'd1;
  localparam logic [2:0] M_K2    = 3'd2;
  localparam logic [2:0] M_K3    = 3'd3;
  localparam logic [2:0] M_K6    = 3'd4;
  localparam logic [2:0] M_K17   = 3'd5;
  localparam logic [2:0] M_K3S16 = 3'd6;

  // addend select
  localparam logic [2:0] B_NONE = 3'd0;
  localparam logic [2:0] B_RA   = 3'd1;
  localparam logic [2:0] B_RB   = 3'd2;
  localparam logic [2:0] B_C0   = 3'd3;
  localparam logic [2:0] B_C1   = 3'd4;
  localparam logic [2:0] B_C2   = 3'd5;

  // product scaling
  localparam logic [1:0] MD_UNS  = 2'd0;
  localparam logic [1:0] MD_TIME = 2'd1;
  localparam logic [1:0] MD_RAW  = 2'd2;

  // destination
  localparam logic [1:0] D_RA = 2'd0;
  localparam logic [1:0] D_RB = 2'd1;
  localparam logic [1:0] D_RC = 2'd2;
  localparam logic [1:0] D_RD = 2'd3;

  localparam logic [3:0] PLAN_FIRST   = 4'd0;
  localparam logic [3:0] PLAN_LAST    = 4'd4;
  localparam logic [3:0] SAMPLE_FIRST = 4'd5;

  typedef struct packed {
    logic [2:0] a_sel;
    logic [2:0] m_sel;
    logic [1:0] mode;
    logic [2:0] b_sel;
    logic       neg;
    logic [1:0] dest;
    logic       last;
  } op_t;

  function automatic op_t ctg_op(input logic [3:0] step);
    op_t o;
    o = '{A_RA, M_T, MD_TIME, B_NONE, 1'b0, D_RA, 1'b0};
    case (step)
      4'd0:    o = '{A_RB, M_DUR,   MD_UNS,  B_NONE, 1'b0, D_RB, 1'b0};
      4'd1:    o = '{A_RA, M_K17,   MD_UNS,  B_RB,   1'b1, D_RB, 1'b0};
      4'd2:    o = '{A_RA, M_K3S16, MD_UNS,  B_NONE, 1'b0, D_RA, 1'b0};
      4'd3:    o = '{A_RC, M_DUR,   MD_UNS,  B_RA,   1'b1, D_RA, 1'b0};
      4'd4:    o = '{A_DUR, M_DUR,  MD_RAW,  B_NONE, 1'b0, D_RC, 1'b1};
      4'd5:    o = '{A_C3, M_T,     MD_TIME, B_C2,   1'b0, D_RA, 1'b0};
      4'd6:    o = '{A_RA, M_T,     MD_TIME, B_C1,   1'b0, D_RA, 1'b0};
      4'd7:    o = '{A_RA, M_T,     MD_TIME, B_C0,   1'b0, D_RA, 1'b0};
      4'd8:    o = '{A_C2, M_K2,    MD_UNS,  B_NONE, 1'b0, D_RB, 1'b0};
      4'd9:    o = '{A_C3, M_K6,    MD_UNS,  B_NONE, 1'b0, D_RC, 1'b0};
      4'd10:   o = '{A_RC, M_T,     MD_TIME, B_RB,   1'b0, D_RC, 1'b0};
      4'd11:   o = '{A_C3, M_K3,    MD_UNS,  B_NONE, 1'b0, D_RD, 1'b0};
      4'd12:   o = '{A_RD, M_T,     MD_TIME, B_RB,   1'b0, D_RD, 1'b0};
      4'd13:   o = '{A_RD, M_T,     MD_TIME, B_C1,   1'b0, D_RD, 1'b1};
      default: o = '{A_RA, M_T,     MD_TIME, B_NONE, 1'b0, D_RA, 1'b1};
    endcase
    return o;
  endfunction

  function automatic coef_t abs_mag(input coef_t a);
    return a[COEF_W-1] ? -a : a;
  endfunction

  function automatic coef_t from_mag(input coef_t mag, input logic neg);
    if (neg) begin
      return mag[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : -mag;
    end
    return mag[COEF_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : mag;
  endfunction

  function automatic coef_t sat_add(input coef_t a, input coef_t b);
    coef_t s;
    s = a + b;
    if (a[COEF_W-1] == b[COEF_W-1] && s[COEF_W-1] != a[COEF_W-1]) begin
      return a[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

@@ rtl/ctg_div.sv @@
// Bit-serial unsigned divider, 128-bit dividend by 64-bit divisor.
// One quotient bit per cycle; depends on ctg_pkg.
module ctg_div
  import ctg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [COEF_W-1:0]  divisor,
  output logic [DIV_W-1:0]   quotient,
  output logic               busy,
  output logic               done
);

  logic [DIV_W-1:0]  num_r;
  logic [COEF_W-1:0] rem_r, rem_nxt, dv_r;
  logic [6:0]        cnt_r;
  logic              busy_r, done_r;
  logic [COEF_W-1:0] shifted;
  logic              take;

  always_comb begin
    shifted = {rem_r[COEF_W-2:0], num_r[DIV_W-1]};
    take    = rem_r[COEF_W-1] || (shifted >= dv_r);
    rem_nxt = take ? shifted - dv_r : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (&cnt_r);
      if (start) begin
        num_r  <= dividend;
        dv_r   <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[DIV_W-2:0], take};
        cnt_r <= cnt_r + 7'd1;
        if (&cnt_r) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quotient = num_r;
  assign busy     = busy_r;
  assign done     = done_r;

endmodule

@@ rtl/cubic_trajectory_generator.sv @@
// A plan transfer (in_tuser = 0) fixes a cubic from start/target position and
// velocity over a duration (at least 66); it gives no result and occupies the
// block for shared 32x32 multiplier work, then for three 128-step divisions
// on the one-bit-per-cycle divider. A sample transfer (in_tuser = 1) runs
// nine saturating multiply or multiply-add steps on the shared multiplier,
// then loads the output register once that register is free. in_tready is
// high only while the block is idle; a finished result waits in the output
// register without holding off the next input transfer.
// Top level; depends on ctg_pkg and ctg_div.
module cubic_trajectory_generator
  import ctg_pkg::*;
#(
  parameter int POSITION_WIDTH = 32,
  parameter int TIME_WIDTH     = 24
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // start_position, start_velocity, target_position, target_velocity,
  // move_duration, sample_time
  input  logic [((4*POSITION_WIDTH+2*TIME_WIDTH+7)/8)*8-1:0] in_tdata,
  // kind
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // position, velocity, acceleration
  output logic [((3*POSITION_WIDTH+7)/8)*8-1:0] out_tdata,
  // finished
  output logic out_tlast
);

  localparam int PW    = POSITION_WIDTH;
  localparam int TW    = TIME_WIDTH;
  localparam int OUT_W = ((3*PW+7)/8)*8;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV2  = 3'd2;
  localparam logic [2:0] ST_DIV3A = 3'd3;
  localparam logic [2:0] ST_DIV3B = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]  state_r;
  logic [3:0]  step_r;
  logic [1:0]  phase_r;
  coef_t       c0_r, c1_r, c2_r, c3_r;
  coef_t       ra_r, rb_r, rc_r, rd_r;
  coef_t       hp_r, lp_r;
  logic [TW-1:0] dur_r, t_r;
  logic        fin_r;
  logic        go_r, go_nxt;
  logic        out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic        out_last_r;

  op_t         op;
  coef_t       a_val, a_mag, b_val, prod, prod_n, res, umag;
  logic [MUL_W-1:0] m_val, mul_x;
  logic [2*MUL_W-1:0] mul_p;
  logic [COEF_W:0] sum65;
  logic        ovf;

  logic [PW-1:0] f_p0, f_v0, f_p1, f_v1;
  logic [TW-1:0] f_md, f_ts, d_min;
  coef_t       p0, v0, p1, v1;

  logic [DIV_W-1:0]  div_dividend, div_q;
  coef_t             div_divisor, q_sat;
  logic              div_busy, div_done;

  logic in_xfer, out_load;

  function automatic logic [PW-1:0] sat_out(input coef_t v);
    if (!v[COEF_W-1] && |v[COEF_W-2:PW-1]) return {1'b0, {(PW-1){1'b1}}};
    if (v[COEF_W-1] && !(&v[COEF_W-2:PW-1])) return {1'b1, {(PW-1){1'b0}}};
    return v[PW-1:0];
  endfunction

  assign f_p0 = in_tdata[PW-1:0];
  assign f_v0 = in_tdata[2*PW-1:PW];
  assign f_p1 = in_tdata[3*PW-1:2*PW];
  assign f_v1 = in_tdata[4*PW-1:3*PW];
  assign f_md = in_tdata[4*PW+TW-1:4*PW];
  assign f_ts = in_tdata[4*PW+2*TW-1:4*PW+TW];

  assign p0 = {{(COEF_W-PW){f_p0[PW-1]}}, f_p0};
  assign v0 = {{(COEF_W-PW){f_v0[PW-1]}}, f_v0};
  assign p1 = {{(COEF_W-PW){f_p1[PW-1]}}, f_p1};
  assign v1 = {{(COEF_W-PW){f_v1[PW-1]}}, f_v1};
  assign d_min = (f_md < TW'(MIN_DURATION)) ? TW'(MIN_DURATION) : f_md;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // divider start: after the last plan step, and after each of the first two divisions
  assign go_nxt = ((state_r == ST_MUL) && (phase_r == 2'd2) && op.last &&
                   (step_r == PLAN_LAST)) ||
                  (((state_r == ST_DIV2) || (state_r == ST_DIV3A)) && div_done);

  // shared multiply / saturate / add unit
  always_comb begin
    op = ctg_op(step_r);
    case (op.a_sel)
      A_RA:    a_val = ra_r;
      A_RB:    a_val = rb_r;
      A_RC:    a_val = rc_r;
      A_RD:    a_val = rd_r;
      A_C2:    a_val = c2_r;
      A_C3:    a_val = c3_r;
      A_DUR:   a_val = COEF_W'(dur_r);
      default: a_val = ra_r;
    endcase
    case (op.m_sel)
      M_DUR:   m_val = MUL_W'(dur_r);
      M_T:     m_val = MUL_W'(t_r);
      M_K2:    m_val = MUL_W'(2);
      M_K3:    m_val = MUL_W'(3);
      M_K6:    m_val = MUL_W'(6);
      M_K17:   m_val = MUL_W'(1) << 17;
      M_K3S16: m_val = MUL_W'(3) << 16;
      default: m_val = '0;
    endcase
    case (op.b_sel)
      B_RA:    b_val = ra_r;
      B_RB:    b_val = rb_r;
      B_C0:    b_val = c0_r;
      B_C1:    b_val = c1_r;
      B_C2:    b_val = c2_r;
      default: b_val = '0;
    endcase
    a_mag = abs_mag(a_val);
    mul_x = (phase_r == 2'd0) ? a_mag[COEF_W-1:MUL_W] : a_mag[MUL_W-1:0];
    mul_p = mul_x * m_val;

    sum65 = {1'b0, hp_r[MUL_W-1:0], {MUL_W{1'b0}}} + {1'b0, lp_r};
    if (op.mode == MD_TIME) begin
      ovf  = |hp_r[COEF_W-1:47];
      umag = ovf ? '1 : ({hp_r[47:0], 16'b0} + {16'b0, lp_r[COEF_W-1:16]});
    end else begin
      ovf  = |hp_r[COEF_W-1:MUL_W] | sum65[COEF_W];
      umag = ovf ? '1 : sum65[COEF_W-1:0];
    end
    prod   = (op.mode == MD_RAW) ? lp_r : from_mag(umag, a_val[COEF_W-1]);
    prod_n = op.neg ? -prod : prod;
    res    = (op.b_sel == B_NONE) ? prod_n : sat_add(b_val, prod_n);
  end

  // divider operands
  always_comb begin
    case (state_r)
      ST_DIV2: begin
        div_dividend = DIV_W'(abs_mag(ra_r)) << 16;
        div_divisor  = rc_r;
      end
      ST_DIV3A: begin
        div_dividend = DIV_W'(abs_mag(rb_r)) << 32;
        div_divisor  = rc_r;
      end
      default: begin
        div_dividend = div_q;
        div_divisor  = COEF_W'(dur_r);
      end
    endcase
    q_sat = (|div_q[DIV_W-1:COEF_W]) ? '1 : div_q[COEF_W-1:0];
  end

  ctg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go_r),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= PLAN_FIRST;
      phase_r     <= 2'd0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      c0_r        <= '0;
      c1_r        <= '0;
      c2_r        <= '0;
      c3_r        <= '0;
      dur_r       <= '0;
    end else begin
      go_r <= go_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            phase_r <= 2'd0;
            state_r <= ST_MUL;
            if (!in_tuser) begin
              c0_r   <= p0;
              c1_r   <= v0;
              dur_r  <= d_min;
              ra_r   <= p1 - p0;
              rb_r   <= v0 + v1;
              rc_r   <= (v0 <<< 1) + v1;
              step_r <= PLAN_FIRST;
            end else begin
              t_r    <= (f_ts < dur_r) ? f_ts : dur_r;
              fin_r  <= (f_ts >= dur_r);
              step_r <= SAMPLE_FIRST;
            end
          end
        end
        ST_MUL: begin
          case (phase_r)
            2'd0: begin
              hp_r    <= mul_p;
              phase_r <= 2'd1;
            end
            2'd1: begin
              lp_r    <= mul_p;
              phase_r <= 2'd2;
            end
            default: begin
              phase_r <= 2'd0;
              case (op.dest)
                D_RA:    ra_r <= res;
                D_RB:    rb_r <= res;
                D_RC:    rc_r <= res;
                default: rd_r <= res;
              endcase
              if (op.last) begin
                if (step_r == PLAN_LAST) begin
                  state_r <= ST_DIV2;
                end else begin
                  state_r <= ST_OUT;
                end
              end else begin
                step_r <= step_r + 4'd1;
              end
            end
          endcase
        end
        ST_DIV2: begin
          if (div_done) begin
            c2_r    <= from_mag(q_sat, ra_r[COEF_W-1]);
            state_r <= ST_DIV3A;
          end
        end
        ST_DIV3A: begin
          if (div_done) begin
            state_r <= ST_DIV3B;
          end
        end
        ST_DIV3B: begin
          if (div_done) begin
            c3_r    <= from_mag(q_sat, rb_r[COEF_W-1]);
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_W'({sat_out(rc_r), sat_out(rd_r), sat_out(ra_r)});
      out_last_r <= fin_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !div_busy)
    else $error("input ready while divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV2 || state_r == ST_DIV3A || state_r == ST_DIV3B))
    else $error("divider finished outside a divide state");

  a_plan_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> (state_r == ST_MUL && step_r == PLAN_FIRST))
    else $error("plan transfer did not start the sequencer");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_OUT)
    else $error("result raised without a finished sample");
`endif

endmodule

@@ test/cubic_trajectory_generator_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the cubic trajectory generator: a directed table,
// then random plan/sample transfers, checked against an in-bench predictor or a
// row's own expected result. Depends on ctg_pkg and cubic_trajectory_generator.
module cubic_trajectory_generator_test;
  import ctg_pkg::*;

  localparam int PW = 32;
  localparam int TW = 24;
  localparam int IN_W = ((4*PW+2*TW+7)/8)*8;
  localparam int OUT_W = ((3*PW+7)/8)*8;
  localparam logic KIND_PLAN = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONES64 = '1;
  localparam int HOLD_CYCLES = 3000;
  localparam int PLAN_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic kind;
    logic signed [PW-1:0] p0, v0, p1, v1;
    logic [TW-1:0] dur, st;
  } traj_req_t;

  typedef struct {
    logic [PW-1:0] pos, vel, acc;
    logic fin;
  } traj_res_t;

  typedef struct {
    traj_req_t req;
    bit has_exp;
    traj_res_t exp;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tlast;

  cubic_trajectory_generator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [63:0] coef [4];
  logic [TW-1:0] dur_held;
  traj_res_t expected_q [$];
  table_row_t rows [$];
  int errors = 0;
  int phase = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] magnitude(input logic [63:0] a);
    return a[63] ? -a : a;
  endfunction

  function automatic logic [63:0] signed_from(input logic [63:0] m, input logic neg);
    if (neg) return m[63] ? S64_MIN : -m;
    return m[63] ? S64_MAX : m;
  endfunction

  function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic [63:0] scale_clip(input logic [63:0] a, input logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, magnitude(a)} * {64'd0, m};
    if (p[127:64] != 0) return signed_from(ONES64, a[63]);
    return signed_from(p[63:0], a[63]);
  endfunction

  function automatic logic [63:0] time_scale(input logic [63:0] a, input logic [TW-1:0] t);
    logic [63:0] m, hp, lp;
    m = magnitude(a);
    hp = (m >> 32) * {40'd0, t};
    lp = {32'd0, m[31:0]} * {40'd0, t};
    if (hp >= (64'd1 << 47)) return signed_from(ONES64, a[63]);
    return signed_from((hp << 16) + (lp >> 16), a[63]);
  endfunction

  function automatic logic [63:0] coef_divide(input logic [63:0] num, input int sh,
                                              input logic [TW-1:0] d, input bit extra);
    logic [127:0] q, dd;
    logic [63:0] lo;
    dd = {104'd0, d} * {104'd0, d};
    q = {64'd0, magnitude(num)} << sh;
    q = q / dd;
    if (extra) q = q / {104'd0, d};
    lo = (q[127:64] != 0) ? ONES64 : q[63:0];
    return signed_from(lo, num[63]);
  endfunction

  function automatic logic [PW-1:0] clip_out(input logic [63:0] v);
    if (!v[63] && v > 64'h0000_0000_7fff_ffff) return 32'h7fff_ffff;
    if (v[63] && v < 64'hffff_ffff_8000_0000) return 32'h8000_0000;
    return v[PW-1:0];
  endfunction

  // updates the held trajectory; returns 1 when a result is due
  function automatic bit trajectory_step(input traj_req_t r, output traj_res_t res);
    logic [63:0] p0, v0, p1, v1, dp, n2, n3, q, qd, qdd;
    logic [TW-1:0] d, t;
    res = '{default: '0};
    if (r.kind == KIND_PLAN) begin
      p0 = {{32{r.p0[PW-1]}}, r.p0};
      v0 = {{32{r.v0[PW-1]}}, r.v0};
      p1 = {{32{r.p1[PW-1]}}, r.p1};
      v1 = {{32{r.v1[PW-1]}}, r.v1};
      d = (r.dur < MIN_DURATION) ? TW'(MIN_DURATION) : r.dur;
      dp = p1 - p0;
      n3 = add_clip(scale_clip(v0 + v1, {40'd0, d}), -scale_clip(dp, 64'd1 << 17));
      n2 = add_clip(scale_clip(dp, 64'd3 << 16), -scale_clip(2 * v0 + v1, {40'd0, d}));
      coef[0] = p0;
      coef[1] = v0;
      coef[2] = coef_divide(n2, 16, d, 1'b0);
      coef[3] = coef_divide(n3, 32, d, 1'b1);
      dur_held = d;
      return 1'b0;
    end
    t = (r.st < dur_held) ? r.st : dur_held;
    q = add_clip(coef[2], time_scale(coef[3], t));
    q = add_clip(coef[1], time_scale(q, t));
    q = add_clip(coef[0], time_scale(q, t));
    qd = add_clip(scale_clip(coef[2], 64'd2), time_scale(scale_clip(coef[3], 64'd3), t));
    qd = add_clip(coef[1], time_scale(qd, t));
    qdd = add_clip(scale_clip(coef[2], 64'd2), time_scale(scale_clip(coef[3], 64'd6), t));
    res.pos = clip_out(q);
    res.vel = clip_out(qd);
    res.acc = clip_out(qdd);
    res.fin = (r.st >= dur_held);
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 2000)) - 1000) << 16;
      3: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_time(input logic [TW-1:0] ref_t);
    case ($urandom_range(0, 7))
      0: return '1;
      1: return TW'($urandom_range(0, 80));
      2: return ref_t;
      3: return ref_t + TW'($urandom_range(0, 3)) - 2;
      4: return TW'($urandom_range(0, ref_t));
      default: return TW'($urandom);
    endcase
  endfunction

  task automatic add_row(input logic kind, input logic [31:0] p0, v0, p1, v1,
                         input logic [TW-1:0] dur, st, input bit has_exp,
                         input logic [31:0] pos, vel, acc, input logic fin);
    table_row_t r;
    r.req = '{kind, p0, v0, p1, v1, dur, st};
    r.has_exp = has_exp;
    r.exp = '{pos, vel, acc, fin};
    rows.push_back(r);
  endtask

  task automatic send_item(input traj_req_t r, input bit has_exp, input traj_res_t exp);
    traj_res_t res;
    if (phase == 0 && $urandom_range(0, 99) < 8 || phase == 1 && $urandom_range(0, 99) < 59) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.kind;
    in_tdata <= {r.st, r.dur, r.v1, r.p1, r.v0, r.p0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (trajectory_step(r, res)) expected_q.push_back(has_exp ? exp : res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= phase == 0 ? ($urandom_range(0, 99) >= 59) :
                    phase == 1 ? ($urandom_range(0, 99) >= 8) : 1'b1;
    end
  end

  always @(posedge clk) begin
    traj_res_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", out_tdata);
      end else begin
        exp = expected_q.pop_front();
        if (out_tdata[31:0] !== exp.pos || out_tdata[63:32] !== exp.vel ||
            out_tdata[95:64] !== exp.acc || out_tlast !== exp.fin) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp pos %h vel %h acc %h fin %b, got %h %h %h %b",
                     exp.pos, exp.vel, exp.acc, exp.fin, out_tdata[31:0],
                     out_tdata[63:32], out_tdata[95:64], out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL cubic_trajectory_generator");
        $finish;
      end
    end
  end

  initial begin
    traj_req_t r;
    traj_res_t none;
    logic [TW-1:0] last_dur;
    none = '{default: '0};
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1);
    add_row(KIND_SAMPLE, '1, '1, '1, '1, '1, '1, 1, 0, 0, 0, 1);
    add_row(KIND_PLAN, 0, 0, 0, 0, 0, '1, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 66, 1, 0, 0, 0, 1);
    add_row(KIND_PLAN, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0,
            0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 33, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 65, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 66, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, '1, '1, '1, '1, '1, '1, 0, 0, 0, 0, 0);
    add_row(KIND_PLAN, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, '1, 0,
            0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 24'h80_0000, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 24'hff_fffe, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, '1, 0, 0, 0, 0, 0);
    add_row(KIND_PLAN, 32'h1_0000, 0, 32'h5_0000, 0, 24'h2_0000, 0, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 0, 1, 32'h1_0000, 0, 32'h6_0000, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 24'h1_0000, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 24'h2_0000, 0, 0, 0, 0, 0);
    add_row(KIND_PLAN, 32'hfff0_0000, 32'h3_0000, 32'h20_0000, 32'hffff_0000, 65, 24'h1234,
            0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, '1, '1, '1, '1, '1, 40, 0, 0, 0, 0, 0);
    add_row(KIND_SAMPLE, 0, 0, 0, 0, 0, 66, 0, 0, 0, 0, 0);
    coef = '{default: '0};
    dur_held = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].req, rows[i].has_exp, rows[i].exp);
    last_dur = dur_held;
    for (int n = 0; n < 1700; n++) begin
      if (n == 570) phase = 1;
      if (n == 1140) phase = 2;
      if (n == 300 || n == 900) begin
        in_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (PLAN_CYCLES) @(posedge clk);
      end
      if (n == 400 || n == 1300) hold_reqs++;
      r.kind = ($urandom_range(0, 99) < 20) ? KIND_PLAN : KIND_SAMPLE;
      r.p0 = rand_pos();
      r.v0 = rand_pos();
      r.p1 = rand_pos();
      r.v1 = rand_pos();
      r.dur = ($urandom_range(0, 3) == 0) ? TW'($urandom_range(0, 100)) : TW'($urandom);
      r.st = rand_time(last_dur);
      send_item(r, 1'b0, none);
      last_dur = dur_held;
    end
    in_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (PLAN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS cubic_trajectory_generator");
    end else begin
      $display("FAIL cubic_trajectory_generator");
    end
    $finish;
  end

endmodule

@@ cubic_trajectory_generator.f @@
rtl/ctg_pkg.sv
rtl/ctg_div.sv
rtl/cubic_trajectory_generator.sv
test/cubic_trajectory_generator_test.sv
